// File: hw/rtl/skx_pkg.sv
// package for the sha-256 counter-mode keystream unit
// holds payload structs, round constants and sha-256 helper functions; no dependencies
`default_nettype none
package skx_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    localparam int unsigned NUM_KEY_REGS = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned NUM_ROUNDS   = 64;
    localparam logic [31:0] PAD_WORD     = 32'h8000_0000;
    localparam logic [31:0] MSG_BITS     = 32'd320;

    typedef logic [31:0] word_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t start_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/skx_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module skx_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/skx_core.sv
// sha-256 compression engine: one round per cycle, schedule window kept in a 16-entry ram
// message built from the key and counter; depends on skx_pkg and skx_ram
`default_nettype none
module skx_core #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [255:0]             key,
    input  wire logic [COUNTER_WIDTH-1:0] counter,
    output logic                          done,
    output logic [255:0]                  digest
);
    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_FINAL} state_t;

    state_t       state_reg;
    logic [3:0]   load_reg;
    logic [6:0]   rnd_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [63:0]  ctr_reg;
    // the last 16 schedule words also live in shift registers for the taps
    logic [31:0]  w_reg [16];
    logic         done_reg;

    logic         we;
    logic [3:0]   waddr;
    logic [31:0]  wdata;
    logic [31:0]  rdata;
    logic [31:0]  load_word;
    logic [31:0]  wi;
    logic [31:0]  t1, t2;
    logic [63:0]  ctr_ext;

    assign ctr_ext = 64'(counter);

    // words of the padded message in order
    always_comb
    begin
        case (load_reg)
            4'd0:  load_word = key[255:224];
            4'd1:  load_word = key[223:192];
            4'd2:  load_word = key[191:160];
            4'd3:  load_word = key[159:128];
            4'd4:  load_word = key[127:96];
            4'd5:  load_word = key[95:64];
            4'd6:  load_word = key[63:32];
            4'd7:  load_word = key[31:0];
            4'd8:  load_word = {ctr_reg[7:0], ctr_reg[15:8], ctr_reg[23:16], ctr_reg[31:24]};
            4'd9:  load_word = {ctr_reg[39:32], ctr_reg[47:40], ctr_reg[55:48], ctr_reg[63:56]};
            4'd10: load_word = skx_pkg::PAD_WORD;
            4'd15: load_word = skx_pkg::MSG_BITS;
            default: load_word = 32'd0;
        endcase
    end

    // w[i-16] comes from ram (registered read of entry i&15), taps from shift line
    always_comb
    begin
        if (rnd_reg < 7'd16)
        begin
            wi = rdata;
        end
        else
        begin
            wi = rdata + skx_pkg::sig0(w_reg[1]) + w_reg[9] + skx_pkg::sig1(w_reg[14]);
        end
        t1 = h_reg + skx_pkg::bsig1(e_reg) + ((e_reg & f_reg) ^ (~e_reg & g_reg))
             + skx_pkg::round_k(rnd_reg[5:0]) + wi;
        t2 = skx_pkg::bsig0(a_reg) + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
    end

    assign we    = (state_reg == S_LOAD) || (state_reg == S_ROUND);
    assign waddr = (state_reg == S_LOAD) ? load_reg : rnd_reg[3:0];
    assign wdata = (state_reg == S_LOAD) ? load_word : wi;

    // read address leads by one so data is ready when the round starts
    skx_ram #(.WIDTH(32), .DEPTH(16)) u_sched (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr ((state_reg == S_LOAD) ? 4'd0 : 4'(rnd_reg[3:0] + 4'd1)),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            ctr_reg <= ctr_ext;
            a_reg <= skx_pkg::start_h(3'd0); b_reg <= skx_pkg::start_h(3'd1);
            c_reg <= skx_pkg::start_h(3'd2); d_reg <= skx_pkg::start_h(3'd3);
            e_reg <= skx_pkg::start_h(3'd4); f_reg <= skx_pkg::start_h(3'd5);
            g_reg <= skx_pkg::start_h(3'd6); h_reg <= skx_pkg::start_h(3'd7);
        end
        if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wi;
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
        if (state_reg == S_FINAL)
        begin
            digest <= {a_reg + skx_pkg::start_h(3'd0), b_reg + skx_pkg::start_h(3'd1),
                       c_reg + skx_pkg::start_h(3'd2), d_reg + skx_pkg::start_h(3'd3),
                       e_reg + skx_pkg::start_h(3'd4), f_reg + skx_pkg::start_h(3'd5),
                       g_reg + skx_pkg::start_h(3'd6), h_reg + skx_pkg::start_h(3'd7)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            load_reg  <= 4'd0;
            rnd_reg   <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        load_reg  <= 4'd0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    load_reg <= load_reg + 4'd1;
                    if (load_reg == 4'd15)
                    begin
                        rnd_reg   <= 7'd0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'(skx_pkg::NUM_ROUNDS - 1))
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

// File: hw/rtl/sha256_ctr_keystream_xor_unit.sv
// Keystream cipher unit: each byte is xored with a byte of SHA-256(key || counter, 8 bytes
// little-endian). A new 32-byte keystream block is generated when a byte arrives at position
// zero: the message is loaded into the schedule ram, 64 rounds run at one per cycle, a
// finalize step and a digest pickup follow, the block is written into the keystream ram,
// then come a ram read and the output register for that byte's result. The other 31 bytes
// of a block each go through a keystream ram read, the output register and the output
// transaction before input is ready again, so a new byte is taken only once the last one's
// output is taken. The counter restarts after a byte marked last.
// depends on skx_pkg, skx_ram, skx_core
`default_nettype none
module sha256_ctr_keystream_xor_unit #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire skx_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output skx_pkg::out_item_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_HASH, S_FILL, S_READ, S_OUT} state_t;

    state_t                   state_reg;
    logic [63:0]              key_reg [skx_pkg::NUM_KEY_REGS];
    logic [COUNTER_WIDTH-1:0] ctr_reg;
    logic [4:0]               pos_reg;
    logic [4:0]               fill_reg;
    logic [255:0]             digest_hold_reg;
    skx_pkg::in_item_t        item_reg;
    skx_pkg::out_item_t       out_reg;
    logic                     out_valid_reg;

    logic         core_start;
    logic         core_done;
    logic [255:0] digest;
    logic [7:0]   ks_byte;
    logic         ks_we;
    logic         accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign core_start = accept && (pos_reg == 5'd0);
    assign ks_we     = (state_reg == S_FILL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < skx_pkg::NUM_KEY_REGS; i++)
            begin
                key_reg[i] <= 64'd0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    skx_core #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (core_start),
        .key     ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .counter (ctr_reg),
        .done    (core_done),
        .digest  (digest)
    );

    // keystream ram, filled one byte per cycle from the held digest
    skx_ram #(.WIDTH(8), .DEPTH(32)) u_ks (
        .clk   (clk),
        .we    (ks_we),
        .waddr (fill_reg),
        .wdata (digest_hold_reg[255:248]),
        .raddr (pos_reg),
        .rdata (ks_byte)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (core_done)
        begin
            digest_hold_reg <= digest;
        end
        else if (state_reg == S_FILL)
        begin
            digest_hold_reg <= {digest_hold_reg[247:0], 8'd0};
        end
        if (state_reg == S_OUT)
        begin
            out_reg.out_byte <= item_reg.data_byte ^ ks_byte;
            out_reg.out_last <= item_reg.last_in_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctr_reg       <= '0;
            pos_reg       <= 5'd0;
            fill_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (pos_reg == 5'd0) ? S_HASH : S_READ;
                    end
                end
                S_HASH:
                begin
                    if (core_done)
                    begin
                        fill_reg  <= 5'd0;
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    fill_reg <= fill_reg + 5'd1;
                    if (fill_reg == 5'd31)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // ram read of the current position lands next cycle
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                    if (item_reg.last_in_message)
                    begin
                        ctr_reg <= '0;
                        pos_reg <= 5'd0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 5'd1;
                        if (pos_reg == 5'd31)
                        begin
                            ctr_reg <= ctr_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire
